[src/aging_priority_task_scheduler_defines.svh]
// assertion macros for the aging priority scheduler
`ifndef AGING_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define AGING_PRIORITY_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define APS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication, sampled on clk, off during reset
`define APS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

[src/aps_pkg.sv]
package aps_pkg;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_READY = 2'd1,
        ST_SLEEP = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_YIELD = 3'd1,
        CMD_SLEEP = 3'd2,
        CMD_ADMIT = 3'd3,
        CMD_EXIT  = 3'd4
    } cmd_t;

    typedef logic signed [5:0] prio_t;
    typedef logic signed [7:0] age_t;
    typedef logic signed [8:0] key_t;

    localparam age_t       AGE_MIN       = 8'sh80;
    localparam logic [7:0] QUANTUM_RESET = 8'd20;

    typedef struct packed {
        logic    prio_we;
        logic    age_we;
        logic    wake_we;
        logic    st_we;
        status_t st_val;
    } tbl_wr_t;

endpackage

[src/aps_key_unit.sv]
module aps_key_unit
(
    input  aps_pkg::prio_t prio,
    input  aps_pkg::age_t  age,
    input  aps_pkg::key_t  best_key,
    input  logic           best_found,
    output aps_pkg::key_t  key,
    output logic           take
);

    assign key  = aps_pkg::key_t'(prio) + aps_pkg::key_t'(age);
    assign take = !best_found || (key < best_key);

endmodule

[src/aps_slot_table.sv]
module aps_slot_table
#(
    parameter int MAX_TASKS = 16,
    parameter int SLOT_W    = 4,
    parameter int CNT_W     = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  aps_pkg::tbl_wr_t    wr,
    input  logic [SLOT_W-1:0]   wr_addr,
    input  aps_pkg::prio_t      prio_d,
    input  aps_pkg::age_t       age_d,
    input  logic [31:0]         wake_d,
    input  logic [SLOT_W-1:0]   rd_addr,
    output aps_pkg::prio_t      prio_q,
    output aps_pkg::age_t       age_q,
    output logic [31:0]         wake_q,
    input  logic [SLOT_W-1:0]   st_rd_addr,
    output aps_pkg::status_t    st_rd,
    output logic [CNT_W-1:0]    ready_cnt,
    output logic [CNT_W-1:0]    sleep_cnt
);

    aps_pkg::prio_t   prio_mem [MAX_TASKS];
    aps_pkg::age_t    age_mem  [MAX_TASKS];
    logic [31:0]      wake_mem [MAX_TASKS];

    aps_pkg::status_t status_reg [MAX_TASKS];
    logic [CNT_W-1:0] ready_reg;
    logic [CNT_W-1:0] ready_next;
    logic [CNT_W-1:0] sleep_reg;
    logic [CNT_W-1:0] sleep_next;
    aps_pkg::status_t old_st;

    always_ff @(posedge clk)
    begin
        if (wr.prio_we)
        begin
            prio_mem[wr_addr] <= prio_d;
        end
        if (wr.age_we)
        begin
            age_mem[wr_addr] <= age_d;
        end
        if (wr.wake_we)
        begin
            wake_mem[wr_addr] <= wake_d;
        end
        prio_q <= prio_mem[rd_addr];
        age_q  <= age_mem[rd_addr];
        wake_q <= wake_mem[rd_addr];
    end

    assign old_st = status_reg[wr_addr];
    assign st_rd  = status_reg[st_rd_addr];

    always_comb
    begin
        ready_next = ready_reg;
        sleep_next = sleep_reg;
        if (wr.st_we)
        begin
            ready_next = ready_reg
                - CNT_W'(old_st == aps_pkg::ST_READY)
                + CNT_W'(wr.st_val == aps_pkg::ST_READY);
            sleep_next = sleep_reg
                - CNT_W'(old_st == aps_pkg::ST_SLEEP)
                + CNT_W'(wr.st_val == aps_pkg::ST_SLEEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                status_reg[i] <= aps_pkg::ST_EMPTY;
            end
            ready_reg <= '0;
            sleep_reg <= '0;
        end
        else
        begin
            if (wr.st_we)
            begin
                status_reg[wr_addr] <= wr.st_val;
            end
            ready_reg <= ready_next;
            sleep_reg <= sleep_next;
        end
    end

    assign ready_cnt = ready_reg;
    assign sleep_cnt = sleep_reg;

endmodule

[src/aging_priority_task_scheduler.sv]
// aging priority task scheduler
// command channel: an item (command, task_slot, priority_req, sleep_ticks) is
// taken at a clock edge where start is high and busy is low
// result channel: done pulses for one cycle with running_slot, running_valid,
// switched, ready_count, sleeping_count and now_ticks; the receiver cannot
// stall, so the word must be taken in that cycle
// config channel: cfg_data loads the quantum on cfg_valid, cfg_ready is
// always high
// an admit, a tick that keeps the running task, or an unknown command answers
// one cycle after it is taken, and the next item may follow at once
// a reschedule takes MAX_TASKS + 2 cycles from the accepting edge to done:
// one pass over the slot table, one slot per cycle through a single read port
// of the slot memories and one shared key adder and comparator, which wakes,
// picks and ages in that one pass, then one cycle to clear the winner's age
// busy stays high for the whole pass
// reset empties every slot, stops the clock at zero, leaves no task running
// and loads a quantum of 20 ticks
module aging_priority_task_scheduler
#(
    parameter int MAX_TASKS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         command,
    input  logic [3:0]         task_slot,
    input  logic signed [5:0]  priority_req,
    input  logic [15:0]        sleep_ticks,
    output logic               done,
    output logic [3:0]         running_slot,
    output logic               running_valid,
    output logic               switched,
    output logic [4:0]         ready_count,
    output logic [4:0]         sleeping_count,
    output logic [31:0]        now_ticks,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);

    localparam int SLOT_W  = $clog2(MAX_TASKS);
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int ISSUE_W = $clog2(MAX_TASKS + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [SLOT_W-1:0] cur_slot_reg;
    logic [SLOT_W-1:0] cur_slot_next;
    logic              cur_valid_reg;
    logic              cur_valid_next;
    logic [7:0]        quantum_reg;
    logic [7:0]        quantum_next;
    logic [31:0]       tick_reg;
    logic [31:0]       tick_next;
    logic [7:0]        qticks_reg;
    logic [7:0]        qticks_next;
    logic              switched_reg;
    logic              switched_next;
    logic              done_reg;
    logic              done_next;
    logic [ISSUE_W-1:0] issue_reg;
    logic [ISSUE_W-1:0] issue_next;
    logic              pv_reg;
    logic              pv_next;
    logic [SLOT_W-1:0] pidx_reg;
    logic [SLOT_W-1:0] pidx_next;
    logic              best_found_reg;
    logic              best_found_next;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [SLOT_W-1:0] best_idx_next;
    aps_pkg::key_t     best_key_reg;
    aps_pkg::key_t     best_key_next;

    aps_pkg::tbl_wr_t  wr;
    logic [SLOT_W-1:0] wr_addr;
    aps_pkg::prio_t    prio_d;
    aps_pkg::age_t     age_d;
    logic [31:0]       wake_d;
    logic [SLOT_W-1:0] rd_addr;
    aps_pkg::prio_t    prio_q;
    aps_pkg::age_t     age_q;
    logic [31:0]       wake_q;
    aps_pkg::status_t  st_rd;
    logic [CNT_W-1:0]  ready_cnt;
    logic [CNT_W-1:0]  sleep_cnt;

    aps_pkg::key_t     key;
    logic              take;
    logic              issue_lt;
    logic [31:0]       wake_diff;
    logic              due;
    logic              eff_ready;
    logic              sw;

    aps_slot_table
    #(
        .MAX_TASKS (MAX_TASKS),
        .SLOT_W    (SLOT_W),
        .CNT_W     (CNT_W)
    )
    u_table
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .wr_addr    (wr_addr),
        .prio_d     (prio_d),
        .age_d      (age_d),
        .wake_d     (wake_d),
        .rd_addr    (rd_addr),
        .prio_q     (prio_q),
        .age_q      (age_q),
        .wake_q     (wake_q),
        .st_rd_addr (pidx_reg),
        .st_rd      (st_rd),
        .ready_cnt  (ready_cnt),
        .sleep_cnt  (sleep_cnt)
    );

    aps_key_unit u_key
    (
        .prio       (prio_q),
        .age        (age_q),
        .best_key   (best_key_reg),
        .best_found (best_found_reg),
        .key        (key),
        .take       (take)
    );

    assign issue_lt  = issue_reg < ISSUE_W'(MAX_TASKS);
    assign wake_diff = tick_reg - wake_q;
    assign due       = ~wake_diff[31];
    assign eff_ready = (st_rd == aps_pkg::ST_READY)
                    || ((st_rd == aps_pkg::ST_SLEEP) && due);

    always_comb
    begin
        state_next      = state_reg;
        cur_slot_next   = cur_slot_reg;
        cur_valid_next  = cur_valid_reg;
        quantum_next    = quantum_reg;
        tick_next       = tick_reg;
        qticks_next     = qticks_reg;
        switched_next   = switched_reg;
        done_next       = 1'b0;
        issue_next      = issue_reg;
        pv_next         = 1'b0;
        pidx_next       = pidx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_key_next   = best_key_reg;
        wr              = '{prio_we: 1'b0, age_we: 1'b0, wake_we: 1'b0,
                            st_we: 1'b0, st_val: aps_pkg::ST_EMPTY};
        wr_addr         = cur_slot_reg;
        prio_d          = priority_req;
        age_d           = '0;
        wake_d          = tick_reg + 32'(sleep_ticks);
        rd_addr         = '0;
        sw              = 1'b0;

        if (cfg_valid)
        begin
            qticks_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (command)
                        aps_pkg::CMD_TICK:
                        begin
                            tick_next = tick_reg + 32'd1;
                            if (cur_valid_reg)
                            begin
                                if (quantum_reg <= 8'd1)
                                begin
                                    sw = 1'b1;
                                end
                                else
                                begin
                                    quantum_next = quantum_reg - 8'd1;
                                end
                            end
                            else
                            begin
                                sw = (ready_cnt != '0) || (sleep_cnt != '0);
                            end
                        end
                        aps_pkg::CMD_YIELD:
                        begin
                            sw = 1'b1;
                        end
                        aps_pkg::CMD_SLEEP:
                        begin
                            if (cur_valid_reg)
                            begin
                                wr.wake_we = 1'b1;
                                wr.st_we   = 1'b1;
                                wr.st_val  = aps_pkg::ST_SLEEP;
                            end
                            sw = 1'b1;
                        end
                        aps_pkg::CMD_ADMIT:
                        begin
                            if (int'(task_slot) < MAX_TASKS)
                            begin
                                wr_addr    = SLOT_W'(task_slot);
                                wr.prio_we = 1'b1;
                                wr.age_we  = 1'b1;
                                wr.st_we   = 1'b1;
                                wr.st_val  = aps_pkg::ST_READY;
                            end
                        end
                        aps_pkg::CMD_EXIT:
                        begin
                            if (cur_valid_reg)
                            begin
                                wr.st_we  = 1'b1;
                                wr.st_val = aps_pkg::ST_EMPTY;
                            end
                            sw = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                    switched_next = sw;
                    if (sw)
                    begin
                        state_next      = S_SCAN;
                        issue_next      = '0;
                        best_found_next = 1'b0;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                // read slot n while slot n-1 is judged
                if (issue_lt)
                begin
                    rd_addr    = SLOT_W'(issue_reg);
                    issue_next = issue_reg + ISSUE_W'(1);
                    pv_next    = 1'b1;
                    pidx_next  = SLOT_W'(issue_reg);
                end
                if (pv_reg)
                begin
                    wr_addr = pidx_reg;
                    if ((st_rd == aps_pkg::ST_SLEEP) && due)
                    begin
                        wr.st_we  = 1'b1;
                        wr.st_val = aps_pkg::ST_READY;
                    end
                    if (eff_ready)
                    begin
                        if (age_q != aps_pkg::AGE_MIN)
                        begin
                            wr.age_we = 1'b1;
                            age_d     = age_q - 8'sd1;
                        end
                        if (take)
                        begin
                            best_found_next = 1'b1;
                            best_idx_next   = pidx_reg;
                            best_key_next   = key;
                        end
                    end
                    if (pidx_reg == SLOT_W'(MAX_TASKS - 1))
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (best_found_reg)
                begin
                    wr_addr        = best_idx_reg;
                    wr.age_we      = 1'b1;
                    age_d          = '0;
                    cur_slot_next  = best_idx_reg;
                    cur_valid_next = 1'b1;
                    quantum_next   = qticks_reg;
                end
                else
                begin
                    cur_slot_next  = '0;
                    cur_valid_next = 1'b0;
                    quantum_next   = '0;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_slot_reg   <= '0;
            cur_valid_reg  <= 1'b0;
            quantum_reg    <= '0;
            tick_reg       <= '0;
            qticks_reg     <= aps_pkg::QUANTUM_RESET;
            switched_reg   <= 1'b0;
            done_reg       <= 1'b0;
            issue_reg      <= '0;
            pv_reg         <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_slot_reg   <= cur_slot_next;
            cur_valid_reg  <= cur_valid_next;
            quantum_reg    <= quantum_next;
            tick_reg       <= tick_next;
            qticks_reg     <= qticks_next;
            switched_reg   <= switched_next;
            done_reg       <= done_next;
            issue_reg      <= issue_next;
            pv_reg         <= pv_next;
            best_found_reg <= best_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg     <= pidx_next;
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign done           = done_reg;
    assign running_slot   = 4'(cur_slot_reg);
    assign running_valid  = cur_valid_reg;
    assign switched       = switched_reg;
    assign ready_count    = 5'(ready_cnt);
    assign sleeping_count = 5'(sleep_cnt);
    assign now_ticks      = tick_reg;

`include "aging_priority_task_scheduler_defines.svh"

    `APS_ASSERT_IMP(a_cnt_bound, 1'b1, (32'(ready_cnt) + 32'(sleep_cnt)) <= MAX_TASKS)
    `APS_ASSERT_IMP(a_idle_slot_zero, done && !running_valid, running_slot == 4'd0)
    `APS_ASSERT_NXT(a_accept_progress, start && !busy, busy || done)
    `APS_ASSERT_NXT(a_finish_done, state_reg == S_FINISH, done && !busy)

endmodule
